// ----- sv/rsqs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the quarter-wave sine table for the sprite quad setup.
// No dependencies; every other file but rsqs_ram refers to this package by scoped names.
package rsqs_pkg;

    localparam int MAX_SPRITES  = 2048;
    localparam int SINE_ENTRIES = 1024;
    localparam int FULL_TURN    = 92160;
    localparam int QUARTER_TURN = 23040;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int SIZE_W   = 31;
    localparam int ANGLE_W  = 18;
    localparam int COLOR_W  = 32;
    localparam int TEX_W    = 16;
    localparam int CORNER_W = 2;
    localparam int VIDX_W   = 13;

    localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

    localparam int HALF_W    = SIZE_W - 1;
    localparam int CNT_W     = $clog2(MAX_SPRITES + 1);
    localparam int TH_W      = $clog2(FULL_TURN);
    localparam int R_W       = $clog2(QUARTER_TURN);
    localparam int SINE_W    = 16;
    localparam int FRAC_BITS = 15;
    localparam int TAB_DEPTH = SINE_ENTRIES + 1;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    // Table index = r * SINE_ENTRIES / QUARTER_TURN by reciprocal multiply, exact over range
    localparam logic [63:0] P_MAX     = 64'(QUARTER_TURN - 1) * 64'(SINE_ENTRIES);
    localparam int          P_W       = $clog2(P_MAX + 64'd1);
    localparam int          IDX_SHIFT = $clog2(P_MAX * 64'(QUARTER_TURN)) + 1;
    localparam logic [63:0] IDX_RECIP =
        ((64'd1 << IDX_SHIFT) + 64'(QUARTER_TURN) - 64'd1) / 64'(QUARTER_TURN);
    localparam int          RECIP_W   = $clog2(IDX_RECIP + 64'd1);
    localparam int          IDXP_W    = P_W + RECIP_W;

    // Size times sine magnitude, and the same with room for a sign
    localparam int MAG_W   = HALF_W + SINE_W;
    localparam int SPROD_W = MAG_W + 1;

    typedef logic [SINE_W-1:0] sine_tab_t [TAB_DEPTH];

    // Quarter-wave sine in Q1.15 from an eleven-term Taylor sum in Q2.30
    function automatic sine_tab_t build_sine();
        sine_tab_t          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        e;
        logic signed [63:0] sum;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            // Term k divides by (2k)(2k+1); odd terms subtract
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd342;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd420;
            sum  = sum + $signed(term);
            if (sum < 0)
            begin
                sum = 64'sd0;
            end
            e = (64'(sum) + 64'd16384) >> 15;
            if (e > 64'd32768)
            begin
                e = 64'd32768;
            end
            tab[i] = SINE_W'(e);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    // One sprite, ready for vertex emission: centre plus the four offset terms
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] e;    // A - D
        logic [COORD_W-1:0] f;    // A + D
        logic [COORD_W-1:0] g;    // B + C
        logic [COORD_W-1:0] h;    // B - C
        logic [COLOR_W-1:0] color;
        logic [TEX_W-1:0]   u1;
        logic [TEX_W-1:0]   v1;
        logic [TEX_W-1:0]   u2;
        logic [TEX_W-1:0]   v2;
        logic [CNT_W-1:0]   num;
        logic               full;
    } quad_t;

endpackage

// ----- sv/rsqs_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sprites in and quad vertices out.
// Depends on rsqs_pkg for field widths.
interface rsqs_sprite_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  new_batch;
    logic signed [rsqs_pkg::COORD_W-1:0]   centre_x;
    logic signed [rsqs_pkg::COORD_W-1:0]   centre_y;
    logic        [rsqs_pkg::SIZE_W-1:0]    size_w;
    logic        [rsqs_pkg::SIZE_W-1:0]    size_h;
    logic signed [rsqs_pkg::ANGLE_W-1:0]   angle_deg;
    logic        [rsqs_pkg::COLOR_W-1:0]   color_rgba;
    logic        [rsqs_pkg::TEX_W-1:0]     tex_u_left;
    logic        [rsqs_pkg::TEX_W-1:0]     tex_v_top;
    logic        [rsqs_pkg::TEX_W-1:0]     tex_u_right;
    logic        [rsqs_pkg::TEX_W-1:0]     tex_v_bottom;

    modport source (
        output valid, new_batch, centre_x, centre_y, size_w, size_h, angle_deg,
               color_rgba, tex_u_left, tex_v_top, tex_u_right, tex_v_bottom,
        input  ready
    );
    modport sink (
        input  valid, new_batch, centre_x, centre_y, size_w, size_h, angle_deg,
               color_rgba, tex_u_left, tex_v_top, tex_u_right, tex_v_bottom,
        output ready
    );
endinterface

interface rsqs_vertex_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rsqs_pkg::COORD_W-1:0]   vert_x;
    logic signed [rsqs_pkg::COORD_W-1:0]   vert_y;
    logic        [rsqs_pkg::COLOR_W-1:0]   vert_color;
    logic        [rsqs_pkg::TEX_W-1:0]     vert_u;
    logic        [rsqs_pkg::TEX_W-1:0]     vert_v;
    logic        [rsqs_pkg::CORNER_W-1:0]  corner;
    logic        [rsqs_pkg::VIDX_W-1:0]    vertex_index;
    logic                                  batch_full;
    logic                                  last;

    modport source (
        output valid, vert_x, vert_y, vert_color, vert_u, vert_v, corner,
               vertex_index, batch_full, last,
        input  ready
    );
    modport sink (
        input  valid, vert_x, vert_y, vert_color, vert_u, vert_v, corner,
               vertex_index, batch_full, last,
        output ready
    );
endinterface

// ----- sv/rsqs_ram.sv -----
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data with enable.
// No dependencies.
module rsqs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- sv/rsqs_emit.sv -----
`timescale 1ns / 1ps
// Vertex emitter: holds one set-up sprite and sends its four corners through an output register.
// Depends on rsqs_pkg (quad_t, widths) and rsqs_if (vertex channel).
module rsqs_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  quad_valid,
    output logic                  quad_ready,
    input  rsqs_pkg::quad_t       quad,
    rsqs_vertex_if.source         vertex
);

    logic                            busy_reg;
    logic [rsqs_pkg::CORNER_W-1:0]   corner_reg;
    rsqs_pkg::quad_t                 quad_reg;
    logic                            out_valid_reg;

    logic [rsqs_pkg::COORD_W-1:0]    x_reg;
    logic [rsqs_pkg::COORD_W-1:0]    y_reg;
    logic [rsqs_pkg::COLOR_W-1:0]    color_reg;
    logic [rsqs_pkg::TEX_W-1:0]      u_reg;
    logic [rsqs_pkg::TEX_W-1:0]      v_reg;
    logic [rsqs_pkg::CORNER_W-1:0]   out_corner_reg;
    logic [rsqs_pkg::VIDX_W-1:0]     vidx_reg;
    logic                            full_reg;
    logic                            last_reg;

    logic                            load_out;
    logic                            last_corner;
    logic [rsqs_pkg::COORD_W-1:0]    off_x;
    logic [rsqs_pkg::COORD_W-1:0]    off_y;
    logic [rsqs_pkg::COORD_W-1:0]    x_next;
    logic [rsqs_pkg::COORD_W-1:0]    y_next;
    logic [rsqs_pkg::TEX_W-1:0]      u_next;
    logic [rsqs_pkg::TEX_W-1:0]      v_next;

    assign load_out    = busy_reg && (!out_valid_reg || vertex.ready);
    assign last_corner = (corner_reg == rsqs_pkg::CORNER_LAST);
    assign quad_ready  = !busy_reg || (load_out && last_corner);

    // Corners 0/2 use (E,G), corners 1/3 use (F,H); the left pair subtracts
    always_comb
    begin
        off_x  = corner_reg[0] ? quad_reg.f : quad_reg.e;
        off_y  = corner_reg[0] ? quad_reg.h : quad_reg.g;
        x_next = corner_reg[1] ? quad_reg.cx + off_x : quad_reg.cx - off_x;
        y_next = corner_reg[1] ? quad_reg.cy + off_y : quad_reg.cy - off_y;
        u_next = corner_reg[1] ? quad_reg.u2 : quad_reg.u1;
        v_next = (corner_reg[0] ^ corner_reg[1]) ? quad_reg.v1 : quad_reg.v2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (quad_ready)
            begin
                busy_reg <= quad_valid;
            end
            if (load_out)
            begin
                corner_reg <= corner_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (vertex.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (quad_ready)
        begin
            quad_reg <= quad;
        end
        if (load_out)
        begin
            x_reg          <= x_next;
            y_reg          <= y_next;
            color_reg      <= quad_reg.color;
            u_reg          <= u_next;
            v_reg          <= v_next;
            out_corner_reg <= corner_reg;
            vidx_reg       <= rsqs_pkg::VIDX_W'({quad_reg.num, corner_reg});
            full_reg       <= quad_reg.full;
            last_reg       <= last_corner;
        end
    end

    assign vertex.valid        = out_valid_reg;
    assign vertex.vert_x       = x_reg;
    assign vertex.vert_y       = y_reg;
    assign vertex.vert_color   = color_reg;
    assign vertex.vert_u       = u_reg;
    assign vertex.vert_v       = v_reg;
    assign vertex.corner       = out_corner_reg;
    assign vertex.vertex_index = vidx_reg;
    assign vertex.batch_full   = full_reg;
    assign vertex.last         = last_reg;

endmodule

// ----- sv/rotated_sprite_quad_setup.sv -----
`timescale 1ns / 1ps
// Rotated sprite quad setup: angle reduction, sine table lookup, rotation and vertex emission.
// Depends on rsqs_pkg, rsqs_if, rsqs_ram and rsqs_emit.
//
//  Channel  Side  One transaction       Carries
//  sprite   in    one sprite            new_batch, centre, size, angle, colour, texture rect
//  vertex   out   one corner of a quad  position, colour, u/v, corner, index, full, last
//
// Eight-stage elastic pipeline into a vertex emitter. The sustained sprite rate is set by the
// single vertex output register (four transactions per sprite); the emitter takes a new
// sprite as the last corner of the one it holds is loaded into that register.
// After reset the sine RAM is loaded from the table, with sprite.ready low. A stall on
// vertex fills the stages and then drops sprite.ready.
module rotated_sprite_quad_setup (
    input  logic          clk,
    input  logic          rst_n,
    rsqs_sprite_if.sink   sprite,
    rsqs_vertex_if.source vertex
);

    typedef struct packed {
        logic [rsqs_pkg::COORD_W-1:0] cx;
        logic [rsqs_pkg::COORD_W-1:0] cy;
        logic [rsqs_pkg::HALF_W-1:0]  hw;
        logic [rsqs_pkg::HALF_W-1:0]  hh;
        logic [rsqs_pkg::COLOR_W-1:0] color;
        logic [rsqs_pkg::TEX_W-1:0]   u1;
        logic [rsqs_pkg::TEX_W-1:0]   v1;
        logic [rsqs_pkg::TEX_W-1:0]   u2;
        logic [rsqs_pkg::TEX_W-1:0]   v2;
        logic [rsqs_pkg::CNT_W-1:0]   num;
        logic                         full;
        logic                         rotate;
    } side_t;

    // Signed Q16.16 x Q1.15 product, rounded toward minus infinity back to Q16.16
    function automatic logic [rsqs_pkg::COORD_W-1:0] floor_q15(
        input logic [rsqs_pkg::MAG_W-1:0] mag,
        input logic                       neg
    );
        logic [rsqs_pkg::SPROD_W-1:0] sval;
        sval = neg ? rsqs_pkg::SPROD_W'(0) - rsqs_pkg::SPROD_W'(mag)
                   : rsqs_pkg::SPROD_W'(mag);
        return sval[rsqs_pkg::FRAC_BITS +: rsqs_pkg::COORD_W];
    endfunction

    // Stage control
    logic [8:1] v_reg;
    logic [8:1] rdy;
    logic       quad_ready;
    logic       sprite_acc;
    logic       table_ready;

    // Sprite counter
    logic [rsqs_pkg::CNT_W-1:0] count_reg;
    logic [rsqs_pkg::CNT_W-1:0] num_next;
    logic [rsqs_pkg::CNT_W-1:0] count_next;

    // Table load sweep
    logic                        filling_reg;
    logic [rsqs_pkg::TAB_AW-1:0] fill_cnt_reg;
    logic                        fill_we_reg;
    logic [rsqs_pkg::TAB_AW-1:0] fill_addr_reg;
    logic [rsqs_pkg::SINE_W-1:0] fill_data_reg;

    // Pipeline payload
    side_t                       side_next;
    side_t                       side_reg [1:7];
    logic [rsqs_pkg::ANGLE_W-2:0] ang_mag;
    logic [rsqs_pkg::TH_W-1:0]   th_next;
    logic [rsqs_pkg::TH_W-1:0]   s1_th_reg;
    logic [1:0]                  q_next;
    logic [rsqs_pkg::R_W-1:0]    r_next;
    logic [1:0]                  s2_q_reg;
    logic [rsqs_pkg::R_W-1:0]    s2_r_reg;
    logic [1:0]                  s3_q_reg;
    logic [rsqs_pkg::P_W-1:0]    s3_p_reg;
    logic [rsqs_pkg::IDXP_W-1:0] idx_prod;
    logic [1:0]                  s4_q_reg;
    logic [rsqs_pkg::TAB_AW-1:0] s4_idx_reg;
    logic [1:0]                  s5_q_reg;
    logic [rsqs_pkg::SINE_W-1:0] lo_data;
    logic [rsqs_pkg::SINE_W-1:0] hi_data;
    logic [rsqs_pkg::SINE_W-1:0] sin_mag;
    logic [rsqs_pkg::SINE_W-1:0] cos_mag;
    logic [rsqs_pkg::MAG_W-1:0]  s6_a_reg;
    logic [rsqs_pkg::MAG_W-1:0]  s6_b_reg;
    logic [rsqs_pkg::MAG_W-1:0]  s6_c_reg;
    logic [rsqs_pkg::MAG_W-1:0]  s6_d_reg;
    logic                        s6_sin_neg_reg;
    logic                        s6_cos_neg_reg;
    logic [rsqs_pkg::COORD_W-1:0] s7_a_reg;
    logic [rsqs_pkg::COORD_W-1:0] s7_b_reg;
    logic [rsqs_pkg::COORD_W-1:0] s7_c_reg;
    logic [rsqs_pkg::COORD_W-1:0] s7_d_reg;
    rsqs_pkg::quad_t             quad_next;
    rsqs_pkg::quad_t             quad_reg;

    assign table_ready  = !filling_reg && !fill_we_reg;
    assign sprite.ready = rdy[1] && table_ready;
    assign sprite_acc   = sprite.valid && sprite.ready;

    // A stage takes new data when it is empty or its contents move on
    always_comb
    begin
        rdy[8] = !v_reg[8] || quad_ready;
        for (int k = 7; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k + 1];
        end
    end

    // Numbering, angle reduction to one turn
    always_comb
    begin
        num_next   = sprite.new_batch ? '0 : count_reg;
        count_next = (num_next < rsqs_pkg::CNT_W'(rsqs_pkg::MAX_SPRITES))
                     ? num_next + 1'b1 : rsqs_pkg::CNT_W'(rsqs_pkg::MAX_SPRITES);
        ang_mag    = sprite.angle_deg[rsqs_pkg::ANGLE_W-2:0];
        if (rsqs_pkg::TH_W'(ang_mag) >= rsqs_pkg::TH_W'(rsqs_pkg::FULL_TURN))
        begin
            th_next = rsqs_pkg::TH_W'(ang_mag) - rsqs_pkg::TH_W'(rsqs_pkg::FULL_TURN);
        end
        else
        begin
            th_next = rsqs_pkg::TH_W'(ang_mag);
        end
        side_next.cx     = sprite.centre_x;
        side_next.cy     = sprite.centre_y;
        side_next.hw     = sprite.size_w[rsqs_pkg::SIZE_W-1:1];
        side_next.hh     = sprite.size_h[rsqs_pkg::SIZE_W-1:1];
        side_next.color  = sprite.color_rgba;
        side_next.u1     = sprite.tex_u_left;
        side_next.v1     = sprite.tex_v_top;
        side_next.u2     = sprite.tex_u_right;
        side_next.v2     = sprite.tex_v_bottom;
        side_next.num    = num_next;
        side_next.full   = (count_next == rsqs_pkg::CNT_W'(rsqs_pkg::MAX_SPRITES));
        side_next.rotate = !sprite.angle_deg[rsqs_pkg::ANGLE_W-1] && (ang_mag != '0);
    end

    // Quadrant and remainder within it
    always_comb
    begin
        if (s1_th_reg >= rsqs_pkg::TH_W'(3 * rsqs_pkg::QUARTER_TURN))
        begin
            q_next = 2'd3;
            r_next = rsqs_pkg::R_W'(s1_th_reg - rsqs_pkg::TH_W'(3 * rsqs_pkg::QUARTER_TURN));
        end
        else if (s1_th_reg >= rsqs_pkg::TH_W'(2 * rsqs_pkg::QUARTER_TURN))
        begin
            q_next = 2'd2;
            r_next = rsqs_pkg::R_W'(s1_th_reg - rsqs_pkg::TH_W'(2 * rsqs_pkg::QUARTER_TURN));
        end
        else if (s1_th_reg >= rsqs_pkg::TH_W'(rsqs_pkg::QUARTER_TURN))
        begin
            q_next = 2'd1;
            r_next = rsqs_pkg::R_W'(s1_th_reg - rsqs_pkg::TH_W'(rsqs_pkg::QUARTER_TURN));
        end
        else
        begin
            q_next = 2'd0;
            r_next = rsqs_pkg::R_W'(s1_th_reg);
        end
    end

    assign idx_prod = rsqs_pkg::IDXP_W'(s3_p_reg) * rsqs_pkg::IDXP_W'(rsqs_pkg::IDX_RECIP);

    // Odd quadrants swap sine and cosine; sign follows the quadrant
    assign sin_mag = s5_q_reg[0] ? hi_data : lo_data;
    assign cos_mag = s5_q_reg[0] ? lo_data : hi_data;

    always_comb
    begin
        quad_next.cx    = side_reg[7].cx;
        quad_next.cy    = side_reg[7].cy;
        quad_next.e     = s7_a_reg - s7_d_reg;
        quad_next.f     = s7_a_reg + s7_d_reg;
        quad_next.g     = s7_b_reg + s7_c_reg;
        quad_next.h     = s7_b_reg - s7_c_reg;
        quad_next.color = side_reg[7].color;
        quad_next.u1    = side_reg[7].u1;
        quad_next.v1    = side_reg[7].v1;
        quad_next.u2    = side_reg[7].u2;
        quad_next.v2    = side_reg[7].v2;
        quad_next.num   = side_reg[7].num;
        quad_next.full  = side_reg[7].full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            count_reg    <= '0;
            filling_reg  <= 1'b1;
            fill_cnt_reg <= '0;
            fill_we_reg  <= 1'b0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= sprite_acc;
            end
            for (int k = 2; k <= 8; k++) begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
            if (sprite_acc)
            begin
                count_reg <= count_next;
            end
            fill_we_reg <= filling_reg;
            if (filling_reg)
            begin
                if (fill_cnt_reg == rsqs_pkg::TAB_AW'(rsqs_pkg::TAB_DEPTH - 1))
                begin
                    filling_reg <= 1'b0;
                end
                else
                begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_addr_reg <= fill_cnt_reg;
        fill_data_reg <= rsqs_pkg::SINE_TAB[fill_cnt_reg];
        if (rdy[1])
        begin
            side_reg[1] <= side_next;
            s1_th_reg   <= th_next;
        end
        for (int k = 2; k <= 7; k++) begin
            if (rdy[k])
            begin
                side_reg[k] <= side_reg[k - 1];
            end
        end
        if (rdy[2])
        begin
            s2_q_reg <= q_next;
            s2_r_reg <= r_next;
        end
        if (rdy[3])
        begin
            s3_q_reg <= s2_q_reg;
            s3_p_reg <= rsqs_pkg::P_W'(s2_r_reg) * rsqs_pkg::P_W'(rsqs_pkg::SINE_ENTRIES);
        end
        if (rdy[4])
        begin
            s4_q_reg   <= s3_q_reg;
            s4_idx_reg <= rsqs_pkg::TAB_AW'(idx_prod >> rsqs_pkg::IDX_SHIFT);
        end
        if (rdy[5])
        begin
            s5_q_reg <= s4_q_reg;
        end
        if (rdy[6])
        begin
            s6_a_reg       <= rsqs_pkg::MAG_W'(side_reg[5].hw) * rsqs_pkg::MAG_W'(cos_mag);
            s6_b_reg       <= rsqs_pkg::MAG_W'(side_reg[5].hw) * rsqs_pkg::MAG_W'(sin_mag);
            s6_c_reg       <= rsqs_pkg::MAG_W'(side_reg[5].hh) * rsqs_pkg::MAG_W'(cos_mag);
            s6_d_reg       <= rsqs_pkg::MAG_W'(side_reg[5].hh) * rsqs_pkg::MAG_W'(sin_mag);
            s6_sin_neg_reg <= s5_q_reg[1];
            s6_cos_neg_reg <= s5_q_reg[1] ^ s5_q_reg[0];
        end
        if (rdy[7])
        begin
            // Without rotation the offsets reduce to (+-hw, +-hh)
            if (side_reg[6].rotate)
            begin
                s7_a_reg <= floor_q15(s6_a_reg, s6_cos_neg_reg);
                s7_b_reg <= floor_q15(s6_b_reg, s6_sin_neg_reg);
                s7_c_reg <= floor_q15(s6_c_reg, s6_cos_neg_reg);
                s7_d_reg <= floor_q15(s6_d_reg, s6_sin_neg_reg);
            end
            else
            begin
                s7_a_reg <= rsqs_pkg::COORD_W'(side_reg[6].hw);
                s7_b_reg <= '0;
                s7_c_reg <= rsqs_pkg::COORD_W'(side_reg[6].hh);
                s7_d_reg <= '0;
            end
        end
        if (rdy[8])
        begin
            quad_reg <= quad_next;
        end
    end

    // Sine RAM: read sin(idx) and sin(N - idx) together; data held while stage 5 stalls
    rsqs_ram #(
        .WIDTH (rsqs_pkg::SINE_W),
        .DEPTH (rsqs_pkg::TAB_DEPTH)
    ) u_sine_ram (
        .clk     (clk),
        .we      (fill_we_reg),
        .waddr   (fill_addr_reg),
        .wdata   (fill_data_reg),
        .re      (rdy[5]),
        .raddr_a (s4_idx_reg),
        .raddr_b (rsqs_pkg::TAB_AW'(rsqs_pkg::SINE_ENTRIES) - s4_idx_reg),
        .rdata_a (lo_data),
        .rdata_b (hi_data)
    );

    rsqs_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .quad_valid (v_reg[8]),
        .quad_ready (quad_ready),
        .quad       (quad_reg),
        .vertex     (vertex)
    );

endmodule

// ----- dv/rotated_sprite_quad_setup_check.sv -----
`timescale 1ns / 1ps
// Watches the sprite and vertex channels, predicts the four vertices of each quad and compares.
// Depends on rsqs_pkg for widths and constants and on rsqs_if for the channel interfaces.
module rotated_sprite_quad_setup_check (
    input  logic    clk,
    input  logic    rst_n,
    rsqs_sprite_if  sprite,
    rsqs_vertex_if  vertex,
    output int      fault_count,
    output int      vertices_owed
);

    typedef struct packed {
        logic [rsqs_pkg::COORD_W-1:0]  x;
        logic [rsqs_pkg::COORD_W-1:0]  y;
        logic [rsqs_pkg::COLOR_W-1:0]  color;
        logic [rsqs_pkg::TEX_W-1:0]    u;
        logic [rsqs_pkg::TEX_W-1:0]    v;
        logic [rsqs_pkg::CORNER_W-1:0] corner;
        logic [rsqs_pkg::VIDX_W-1:0]   index;
        logic                          full;
        logic                          last;
    } quad_vertex_t;

    logic [15:0]    quarter_sine [0:rsqs_pkg::SINE_ENTRIES];
    quad_vertex_t   awaited_vertices [$];
    int unsigned    batch_sprites;
    int             fail_total;
    quad_vertex_t   seen;
    quad_vertex_t   want;

    // Quarter-wave sine in Q1.15 from an eleven-term Taylor sum in Q2.30
    initial
    begin : build_quarter_sine
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] rounded;
        longint      acc;
        for (int i = 0; i <= rsqs_pkg::SINE_ENTRIES; i++)
        begin
            x    = rsqs_pkg::HALF_PI_Q30 * 64'(i) / 64'(rsqs_pkg::SINE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 10; k++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            rounded = (64'(acc) + 64'd16384) >> 15;
            if (rounded > 64'd32768)
            begin
                rounded = 64'd32768;
            end
            quarter_sine[i] = 16'(rounded);
        end
    end

    // Rotate the half extents about the centre and queue the four corners of the quad
    function automatic void predict_quad_corners();
        longint       hw;
        longint       hh;
        longint       sn;
        longint       co;
        longint       a;
        longint       b;
        longint       c;
        longint       d;
        longint       dx;
        longint       dy;
        longint       sx;
        longint       sy;
        logic [17:0]  ang;
        int unsigned  th;
        int unsigned  r;
        int unsigned  idx;
        int unsigned  num;
        int unsigned  next;
        logic         rotate;
        quad_vertex_t v;
        hw  = longint'(sprite.size_w >> 1);
        hh  = longint'(sprite.size_h >> 1);
        ang = sprite.angle_deg;
        rotate = !ang[17] && (ang != '0);
        a = 0;
        b = 0;
        c = 0;
        d = 0;
        if (sprite.new_batch)
        begin
            batch_sprites = 0;
        end
        num  = batch_sprites;
        next = (num < rsqs_pkg::MAX_SPRITES) ? num + 1 : rsqs_pkg::MAX_SPRITES;
        if (rotate)
        begin
            th  = ang % rsqs_pkg::FULL_TURN;
            r   = th % rsqs_pkg::QUARTER_TURN;
            idx = r * rsqs_pkg::SINE_ENTRIES / rsqs_pkg::QUARTER_TURN;
            case (th / rsqs_pkg::QUARTER_TURN)
                0:
                begin
                    sn = quarter_sine[idx];
                    co = quarter_sine[rsqs_pkg::SINE_ENTRIES - idx];
                end
                1:
                begin
                    sn = quarter_sine[rsqs_pkg::SINE_ENTRIES - idx];
                    co = -longint'(quarter_sine[idx]);
                end
                2:
                begin
                    sn = -longint'(quarter_sine[idx]);
                    co = -longint'(quarter_sine[rsqs_pkg::SINE_ENTRIES - idx]);
                end
                default:
                begin
                    sn = -longint'(quarter_sine[rsqs_pkg::SINE_ENTRIES - idx]);
                    co = quarter_sine[idx];
                end
            endcase
            // arithmetic shift of the signed product floors toward minus infinity
            a = (hw * co) >>> 15;
            b = (hw * sn) >>> 15;
            c = (hh * co) >>> 15;
            d = (hh * sn) >>> 15;
        end
        for (int k = 0; k < 4; k++)
        begin
            sx = (k < 2) ? -1 : 1;
            sy = (k == 1 || k == 2) ? 1 : -1;
            if (rotate)
            begin
                dx = sx * a - sy * d;
                dy = sx * b + sy * c;
            end
            else
            begin
                dx = sx * hw;
                dy = sy * hh;
            end
            v.x      = 32'(sprite.centre_x) + 32'(dx);
            v.y      = 32'(sprite.centre_y) + 32'(dy);
            v.color  = sprite.color_rgba;
            v.u      = (k < 2) ? sprite.tex_u_left : sprite.tex_u_right;
            v.v      = (k == 1 || k == 2) ? sprite.tex_v_top : sprite.tex_v_bottom;
            v.corner = rsqs_pkg::CORNER_W'(k);
            v.index  = rsqs_pkg::VIDX_W'(num * 4 + k);
            v.full   = (next >= rsqs_pkg::MAX_SPRITES);
            v.last   = (v.corner == rsqs_pkg::CORNER_LAST);
            awaited_vertices = {awaited_vertices, v};
        end
        batch_sprites = next;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
        fail_total++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val, got_val);
    endtask

    initial
    begin
        batch_sprites = 0;
        fail_total    = 0;
        fault_count   = 0;
        vertices_owed = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            awaited_vertices.delete();
            batch_sprites = 0;
        end
        else
        begin
            if (sprite.valid && sprite.ready)
            begin
                predict_quad_corners();
            end
            if (vertex.valid && vertex.ready)
            begin
                seen = '{vertex.vert_x, vertex.vert_y, vertex.vert_color, vertex.vert_u,
                         vertex.vert_v, vertex.corner, vertex.vertex_index,
                         vertex.batch_full, vertex.last};
                if (awaited_vertices.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected vertex transaction, expected none, got index %h",
                             $time, seen.index);
                end
                else
                begin
                    want = awaited_vertices.pop_front();
                    if (seen.x !== want.x)
                        flag_field("vert_x", want.x, seen.x);
                    if (seen.y !== want.y)
                        flag_field("vert_y", want.y, seen.y);
                    if (seen.color !== want.color)
                        flag_field("vert_color", want.color, seen.color);
                    if (seen.u !== want.u)
                        flag_field("vert_u", 32'(want.u), 32'(seen.u));
                    if (seen.v !== want.v)
                        flag_field("vert_v", 32'(want.v), 32'(seen.v));
                    if (seen.corner !== want.corner)
                        flag_field("corner", 32'(want.corner), 32'(seen.corner));
                    if (seen.index !== want.index)
                        flag_field("vertex_index", 32'(want.index), 32'(seen.index));
                    if (seen.full !== want.full)
                        flag_field("batch_full", 32'(want.full), 32'(seen.full));
                    if (seen.last !== want.last)
                        flag_field("last", 32'(want.last), 32'(seen.last));
                end
            end
        end
        fault_count   <= fail_total;
        vertices_owed <= awaited_vertices.size();
    end

endmodule

// ----- dv/rotated_sprite_quad_setup_test.sv -----
`timescale 1ns / 1ps
// Top of the sprite quad setup testbench: clock, reset, sprite stimulus, vertex back-pressure.
// Depends on rsqs_pkg, rsqs_if, the block itself and rotated_sprite_quad_setup_check.
module rotated_sprite_quad_setup_test;

    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_SPRITES = 175;
    localparam int CHUNK_SPRITES  = 25;
    localparam int FULL_TURN      = rsqs_pkg::FULL_TURN;
    localparam int QUARTER_TURN   = rsqs_pkg::QUARTER_TURN;

    typedef struct packed {
        logic                          new_batch;
        logic [rsqs_pkg::COORD_W-1:0]  centre_x;
        logic [rsqs_pkg::COORD_W-1:0]  centre_y;
        logic [rsqs_pkg::SIZE_W-1:0]   size_w;
        logic [rsqs_pkg::SIZE_W-1:0]   size_h;
        logic [rsqs_pkg::ANGLE_W-1:0]  angle_deg;
        logic [rsqs_pkg::COLOR_W-1:0]  color_rgba;
        logic [rsqs_pkg::TEX_W-1:0]    tex_u_left;
        logic [rsqs_pkg::TEX_W-1:0]    tex_v_top;
        logic [rsqs_pkg::TEX_W-1:0]    tex_u_right;
        logic [rsqs_pkg::TEX_W-1:0]    tex_v_bottom;
    } sprite_t;

    logic clk;
    logic rst_n;
    int   faults;
    int   vertices_owed;
    int   src_gap_max;
    int   snk_gap_max;
    logic hold_request;

    rsqs_sprite_if sprite_ch ();
    rsqs_vertex_if vertex_ch ();

    rotated_sprite_quad_setup dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sprite (sprite_ch),
        .vertex (vertex_ch)
    );

    rotated_sprite_quad_setup_check quad_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .sprite        (sprite_ch),
        .vertex        (vertex_ch),
        .fault_count   (faults),
        .vertices_owed (vertices_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_sprite(input sprite_t s);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            sprite_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sprite_ch.valid        <= 1'b1;
        sprite_ch.new_batch    <= s.new_batch;
        sprite_ch.centre_x     <= s.centre_x;
        sprite_ch.centre_y     <= s.centre_y;
        sprite_ch.size_w       <= s.size_w;
        sprite_ch.size_h       <= s.size_h;
        sprite_ch.angle_deg    <= s.angle_deg;
        sprite_ch.color_rgba   <= s.color_rgba;
        sprite_ch.tex_u_left   <= s.tex_u_left;
        sprite_ch.tex_v_top    <= s.tex_v_top;
        sprite_ch.tex_u_right  <= s.tex_u_right;
        sprite_ch.tex_v_bottom <= s.tex_v_bottom;
        do @(posedge clk); while (!sprite_ch.ready);
    endtask

    function automatic logic [15:0] random_tex();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    endfunction

    function automatic sprite_t random_sprite(input logic may_restart);
        sprite_t s;
        s.new_batch = may_restart && ($urandom_range(0, 15) == 0);
        s.centre_x  = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : {16'($urandom_range(0, 1023) - 512),
                                                      16'($urandom)};
        s.centre_y  = ($urandom_range(0, 3) == 0) ? $urandom
                                                   : {16'($urandom_range(0, 1023) - 512),
                                                      16'($urandom)};
        s.size_w    = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                   : {7'd0, 8'($urandom), 16'($urandom)};
        s.size_h    = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                   : {7'd0, 8'($urandom), 16'($urandom)};
        case ($urandom_range(0, 4))
            0:       s.angle_deg = 18'($urandom);
            // quadrant edges, one turn and beyond, and minus one
            1:       s.angle_deg = 18'(QUARTER_TURN * $urandom_range(0, 5)
                                       + $urandom_range(0, 2) - 1);
            2:       s.angle_deg = '0;
            default: s.angle_deg = 18'($urandom_range(1, FULL_TURN - 1));
        endcase
        s.color_rgba   = $urandom;
        s.tex_u_left   = random_tex();
        s.tex_v_top    = random_tex();
        s.tex_u_right  = random_tex();
        s.tex_v_bottom = random_tex();
        return s;
    endfunction

    // Vertex side: random holds, plus one long hold-off when asked
    initial
    begin : vertex_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                vertex_ch.ready <= 1'b0;
                hold_request    <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = $urandom_range(0, snk_gap_max);
                if (gap > 0)
                begin
                    vertex_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            vertex_ch.ready <= 1'b1;
            do @(posedge clk); while (!vertex_ch.valid);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sprite_ch.valid && sprite_ch.ready) || (vertex_ch.valid && vertex_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("rotated_sprite_quad_setup verification failed");
        $finish;
    end

    initial
    begin : stimulus
        sprite_t s;
        rst_n                  = 1'b0;
        hold_request           = 1'b0;
        src_gap_max            = 10;
        snk_gap_max            = 10;
        sprite_ch.valid        = 1'b0;
        sprite_ch.new_batch    = 1'b0;
        sprite_ch.centre_x     = '0;
        sprite_ch.centre_y     = '0;
        sprite_ch.size_w       = '0;
        sprite_ch.size_h       = '0;
        sprite_ch.angle_deg    = '0;
        sprite_ch.color_rgba   = '0;
        sprite_ch.tex_u_left   = '0;
        sprite_ch.tex_v_top    = '0;
        sprite_ch.tex_u_right  = '0;
        sprite_ch.tex_v_bottom = '0;
        vertex_ch.ready        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero sprite, wrap at the coordinate extremes, quadrant edges, odd sizes
        send_sprite('{1'b1, 32'h0, 32'h0, 31'h0, 31'h0, 18'd0, 32'h0,
                      16'd0, 16'd0, 16'd0, 16'd0});
        send_sprite('{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                      18'd0, 32'hFFFF_FFFF, 16'd0, 16'd32768, 16'd32768, 16'd0});
        send_sprite('{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                      18'd1, 32'h1234_5678, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_sprite('{1'b0, 32'h0064_0000, 32'h0032_0000, 31'h0003_0001, 31'h0002_0000,
                      18'd11520, 32'hFF00_FF80, 16'd0, 16'd0, 16'd32768, 16'd32768});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h0040_0001, 31'h0020_0003,
                      18'(QUARTER_TURN - 1), 32'h8040_2010, 16'd100, 16'd200, 16'd300, 16'd400});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h0040_0001, 31'h0020_0003,
                      18'(QUARTER_TURN), 32'h8040_2010, 16'd100, 16'd200, 16'd300, 16'd400});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h0040_0001, 31'h0020_0003,
                      18'(2 * QUARTER_TURN), 32'h8040_2010, 16'd1, 16'd2, 16'd3, 16'd4});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h0040_0001, 31'h0020_0003,
                      18'(3 * QUARTER_TURN), 32'h8040_2010, 16'd1, 16'd2, 16'd3, 16'd4});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h0040_0001, 31'h0020_0003,
                      18'(FULL_TURN - 1), 32'h0102_0304, 16'd5, 16'd6, 16'd7, 16'd8});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h0040_0001, 31'h0020_0003,
                      18'(FULL_TURN), 32'h0102_0304, 16'd5, 16'd6, 16'd7, 16'd8});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h0040_0001, 31'h0020_0003,
                      18'(FULL_TURN + 1), 32'h0102_0304, 16'd5, 16'd6, 16'd7, 16'd8});
        send_sprite('{1'b0, 32'h0064_0000, 32'hFFCE_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                      18'h1FFFF, 32'h0102_0304, 16'd5, 16'd6, 16'd7, 16'd8});
        // negative angles leave the quad axis-aligned
        send_sprite('{1'b0, 32'h0010_8000, 32'h0020_4000, 31'h0005_0000, 31'h0003_0000,
                      18'h3FFFF, 32'hDEAD_BEEF, 16'd10, 16'd20, 16'd30, 16'd40});
        send_sprite('{1'b0, 32'h0010_8000, 32'h0020_4000, 31'h0005_0000, 31'h0003_0000,
                      18'h20000, 32'hDEAD_BEEF, 16'd10, 16'd20, 16'd30, 16'd40});
        send_sprite('{1'b1, 32'h0010_8000, 32'h0020_4000, 31'h0005_0000, 31'h0003_0000,
                      18'(-FULL_TURN), 32'hDEAD_BEEF, 16'd10, 16'd20, 16'd30, 16'd40});
        send_sprite('{1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 31'h1, 31'h1,
                      18'd256, 32'h5555_AAAA, 16'd32768, 16'd0, 16'd0, 16'd32768});
        send_sprite('{1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 31'h3, 31'h2,
                      18'd46000, 32'hAAAA_5555, 16'd0, 16'd32768, 16'd32768, 16'd0});

        // Random sprites in chunks, each chunk with its own idling on both sides
        for (int chunk = 0; chunk < RANDOM_SPRITES / CHUNK_SPRITES; chunk++)
        begin
            if (chunk == 0)
            begin
                src_gap_max = 10;
                snk_gap_max = 10;
            end
            else if (chunk == 3)
            begin
                // stall the vertex side for a long stretch while sprites keep coming
                src_gap_max = 0;
                snk_gap_max = 2;
                hold_request <= 1'b1;
            end
            else if (chunk == 5)
            begin
                src_gap_max = 0;
                snk_gap_max = 0;
            end
            else
            begin
                src_gap_max = 10 * $urandom_range(0, 1);
                snk_gap_max = 10 * $urandom_range(0, 1);
            end
            for (int n = 0; n < CHUNK_SPRITES; n++)
            begin
                s = random_sprite(1'b1);
                send_sprite(s);
            end
        end

        // restart the batch for the last few sprites
        src_gap_max = 10;
        snk_gap_max = 10;
        for (int n = 0; n < 3; n++)
        begin
            s = random_sprite(1'b0);
            s.new_batch = (n == 0);
            send_sprite(s);
        end
        sprite_ch.valid <= 1'b0;

        @(posedge clk);
        while (vertices_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0 && vertices_owed == 0)
            $display("rotated_sprite_quad_setup verification clean");
        else
            $display("rotated_sprite_quad_setup verification failed");
        $finish;
    end

endmodule
